>>> rtl/r2a_pkg.sv
`timescale 1ns / 1ps
// Shared constants and the digit-to-character mapping for the radix-to-ASCII
// converter. No dependencies.
package r2a_pkg;

	localparam int VALUE_BITS_DEF     = 32;
	localparam int STACK_DEPTH_DEF    = 32;
	localparam int RADIX_W            = 6;
	localparam int CHAR_W             = 7;
	localparam int DIV_BITS_PER_CYCLE = 8;
	localparam int QUEUE_DEPTH        = 2;
	localparam int RADIX_MIN          = 2;
	localparam int RADIX_MAX          = 36;
	localparam int DECIMAL_DIGITS     = 10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;

	// Digit values 0..9 map to '0'..'9', 10..35 to 'A'..'Z'.
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d < RADIX_W'(DECIMAL_DIGITS))
			return CHAR_ZERO + dx;
		return CHAR_UPPER_A + dx - CHAR_W'(DECIMAL_DIGITS);
	endfunction

endpackage

>>> rtl/r2a_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the radix-to-ASCII converter: number input and digit output.
// Depends on r2a_pkg.
interface r2a_in_if #(
	parameter int VALUE_BITS = r2a_pkg::VALUE_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic signed [VALUE_BITS-1:0]       number_value;
	logic        [r2a_pkg::RADIX_W-1:0] target_radix;

	modport source (output valid, output number_value, output target_radix, input ready);
	modport sink   (input valid, input number_value, input target_radix, output ready);
endinterface

interface r2a_out_if;
	logic                       valid;
	logic                       ready;
	logic [r2a_pkg::CHAR_W-1:0] digit_char;
	logic                       last_digit;

	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> rtl/r2a_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module r2a_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/r2a_front.sv
`timescale 1ns / 1ps
// Front end: takes number transactions, forms the saturated magnitude and the
// clamped radix, and queues the job for the back end. Depends on r2a_pkg, r2a_if.
module r2a_front #(
	parameter int VALUE_BITS = r2a_pkg::VALUE_BITS_DEF,
	localparam int MAG_BITS  = VALUE_BITS - 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	r2a_in_if.sink                      number_ch,
	output logic                        job_valid,
	input  logic                        job_ready,
	output logic [MAG_BITS-1:0]         job_mag,
	output logic [r2a_pkg::RADIX_W-1:0] job_radix
);

	localparam int QPTR_W = (r2a_pkg::QUEUE_DEPTH > 1) ? $clog2(r2a_pkg::QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(r2a_pkg::QUEUE_DEPTH + 1);

	logic [VALUE_BITS-1:0]         raw;
	logic [VALUE_BITS-1:0]         mag_full;
	logic [MAG_BITS-1:0]           mag;
	logic [r2a_pkg::RADIX_W-1:0]   radix;

	logic [MAG_BITS-1:0]           qmag_q   [r2a_pkg::QUEUE_DEPTH];
	logic [r2a_pkg::RADIX_W-1:0]   qradix_q [r2a_pkg::QUEUE_DEPTH];
	logic [QPTR_W-1:0]             wptr_q, rptr_q;
	logic [QCNT_W-1:0]             qcnt_q;
	logic                          push, pop;

	// Magnitude; the most negative value saturates to the largest positive one.
	always_comb begin
		raw      = number_ch.number_value;
		mag_full = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
		mag      = mag_full[VALUE_BITS-1] ? '1 : mag_full[MAG_BITS-1:0];
	end

	always_comb begin
		if (number_ch.target_radix < r2a_pkg::RADIX_W'(r2a_pkg::RADIX_MIN))
			radix = r2a_pkg::RADIX_W'(r2a_pkg::RADIX_MIN);
		else if (number_ch.target_radix > r2a_pkg::RADIX_W'(r2a_pkg::RADIX_MAX))
			radix = r2a_pkg::RADIX_W'(r2a_pkg::RADIX_MAX);
		else
			radix = number_ch.target_radix;
	end

	assign number_ch.ready = (qcnt_q != QCNT_W'(r2a_pkg::QUEUE_DEPTH));
	assign push            = number_ch.valid && number_ch.ready;
	assign job_valid       = (qcnt_q != '0);
	assign pop             = job_valid && job_ready;
	assign job_mag         = qmag_q[rptr_q];
	assign job_radix       = qradix_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			qmag_q[wptr_q]   <= mag;
			qradix_q[wptr_q] <= radix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			qcnt_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == QPTR_W'(r2a_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == QPTR_W'(r2a_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				qcnt_q <= qcnt_q + 1'b1;
			else if (pop && !push)
				qcnt_q <= qcnt_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_qcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= QCNT_W'(r2a_pkg::QUEUE_DEPTH))
		else $error("job queue count beyond depth");
	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(qcnt_q == QCNT_W'(r2a_pkg::QUEUE_DEPTH) && !pop) |=> qcnt_q == $past(qcnt_q))
		else $error("job queue changed while full and not popped");
`endif

endmodule

>>> rtl/r2a_back.sv
`timescale 1ns / 1ps
// Back end: iterative divider by the radix, digit stack in RAM, pop sequencer
// and output register. Depends on r2a_pkg, r2a_if, r2a_ram.
module r2a_back #(
	parameter int VALUE_BITS  = r2a_pkg::VALUE_BITS_DEF,
	parameter int STACK_DEPTH = r2a_pkg::STACK_DEPTH_DEF,
	localparam int MAG_BITS   = VALUE_BITS - 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  logic [MAG_BITS-1:0]         job_mag,
	input  logic [r2a_pkg::RADIX_W-1:0] job_radix,
	r2a_out_if.source                   digit_ch
);

	localparam int K      = r2a_pkg::DIV_BITS_PER_CYCLE;
	localparam int STEPS  = (MAG_BITS + K - 1) / K;
	localparam int DIV_W  = STEPS * K;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int RW     = r2a_pkg::RADIX_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_RD   = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t                        state_q, state_d;
	logic [DIV_W-1:0]              work_q, work_nx, w;
	logic [RW-1:0]                 rem_q, rem_nx, r;
	logic [RW:0]                   t;
	logic [RW-1:0]                 radix_q;
	logic [STEP_W-1:0]             step_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          last_step;
	logic                          push;
	logic                          out_load;
	logic                          out_vld_q;
	logic [r2a_pkg::CHAR_W-1:0]    char_q;
	logic                          last_q;
	logic [RW-1:0]                 rd_digit;
	logic [AW-1:0]                 rd_addr;

	// Restoring division, K quotient bits per cycle; the work register shifts the
	// dividend out at the top and the quotient in at the bottom.
	always_comb begin
		w = work_q;
		r = rem_q;
		t = '0;
		for (int i = 0; i < K; i++) begin
			t = {r, w[DIV_W-1]};
			w = {w[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, radix_q}) begin
				t    = t - {1'b0, radix_q};
				w[0] = 1'b1;
			end
			r = t[RW-1:0];
		end
		work_nx = w;
		rem_nx  = r;
	end

	assign last_step = (step_q == STEP_W'(STEPS - 1));
	assign push      = (state_q == S_DIV) && last_step && (cnt_q < CNT_W'(STACK_DEPTH));
	assign out_load  = (state_q == S_OUT) && (!out_vld_q || digit_ch.ready);
	assign job_ready = (state_q == S_IDLE);
	assign rd_addr   = AW'(cnt_q - 1'b1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (job_valid) state_d = S_DIV;
			S_DIV:  if (last_step && work_nx == '0) state_d = S_RD;
			S_RD:   state_d = S_OUT;
			S_OUT: begin
				if (out_load)
					state_d = (cnt_q == '0) ? S_IDLE : S_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					cnt_q  <= '0;
				end
				S_DIV: begin
					step_q <= last_step ? '0 : step_q + 1'b1;
					if (push)
						cnt_q <= cnt_q + 1'b1;
				end
				S_RD:  cnt_q <= cnt_q - 1'b1;
				S_OUT: ;
				default: ;
			endcase
			if (out_load)
				out_vld_q <= 1'b1;
			else if (digit_ch.ready)
				out_vld_q <= 1'b0;
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && job_valid) begin
			work_q  <= DIV_W'(job_mag);
			rem_q   <= '0;
			radix_q <= job_radix;
		end else if (state_q == S_DIV) begin
			work_q <= work_nx;
			rem_q  <= last_step ? '0 : rem_nx;
		end
		if (out_load) begin
			char_q <= r2a_pkg::digit_to_ascii(rd_digit);
			last_q <= (cnt_q == '0);
		end
	end

	r2a_ram #(
		.WIDTH (RW),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (AW'(cnt_q)),
		.wdata (rem_nx),
		.re    (state_q == S_RD),
		.raddr (rd_addr),
		.rdata (rd_digit)
	);

	assign digit_ch.valid      = out_vld_q;
	assign digit_ch.digit_char = char_q;
	assign digit_ch.last_digit = last_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("digit count beyond stack depth");
	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < radix_q))
		else $error("partial remainder not below radix");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && state_d == S_RD) |=> (cnt_q != '0))
		else $error("pop phase started with empty stack");
	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && cnt_q == '0) |=> (state_q == S_IDLE && last_q))
		else $error("final digit did not end the conversion");
`endif

endmodule

>>> rtl/radix_to_ascii_digits_top.sv
`timescale 1ns / 1ps
// Radix-to-ASCII converter, top level. Ties the front end, job queue and
// back end together. Depends on r2a_pkg, r2a_if, r2a_front, r2a_back, r2a_ram.
//
// Converts the magnitude of a signed number to ASCII digits in radix 2..36
// ('0'-'9', then 'A'-'Z'), most significant digit first, one output transaction
// per digit, with last_digit set on the final one. The sign is dropped; the most
// negative value saturates to the largest positive one, a radix below 2 acts as
// 2 and one above 36 acts as 36; zero gives the single digit '0'. A front end
// accepts a number transaction whenever its queue has room and holds up to two
// jobs, so inputs keep flowing while the back end works until the queue is full.
// The back end converts one job at a time: each digit comes from the shared
// divider, which resolves eight quotient bits per cycle against the radix, and
// each digit then leaves the stack RAM through the registered read and the
// output register. The output register lets the next job start dividing while
// the last digit waits.
module radix_to_ascii_digits_top #(
	parameter int VALUE_BITS  = r2a_pkg::VALUE_BITS_DEF,
	parameter int STACK_DEPTH = r2a_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	r2a_in_if.sink     number_ch,
	r2a_out_if.source  digit_ch
);

	localparam int MAG_BITS = VALUE_BITS - 1;

	// Job hand-off from the front queue to the back end.
	logic                        job_valid;
	logic                        job_ready;
	logic [MAG_BITS-1:0]         job_mag;
	logic [r2a_pkg::RADIX_W-1:0] job_radix;

	// Classify and queue incoming number transactions.
	r2a_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.number_ch (number_ch),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_mag   (job_mag),
		.job_radix (job_radix)
	);

	// Divide, stack the digits, pop them out through the output register.
	r2a_back #(
		.VALUE_BITS  (VALUE_BITS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_mag   (job_mag),
		.job_radix (job_radix),
		.digit_ch  (digit_ch)
	);

endmodule

>>> test/radix_to_ascii_digits_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_to_ascii_digits_top: number transactions in,
// expected digit strings predicted locally and checked against digit transactions.
// Depends on r2a_pkg, r2a_if and the converter RTL.
module radix_to_ascii_digits_top_test;

	localparam int VALUE_W        = r2a_pkg::VALUE_BITS_DEF;
	localparam int RW             = r2a_pkg::RADIX_W;
	localparam int CW             = r2a_pkg::CHAR_W;
	localparam int STALL_LIMIT    = 4000;  // cycles with no transaction on either channel
	localparam int SETTLE_CYCLES  = 250;
	localparam int HOLD_OFF_LEN   = 300;
	localparam int MAX_PRINTED    = 40;

	// One expected digit transaction.
	typedef struct packed {
		logic [CW-1:0] digit_char;
		logic          last_digit;
	} digit_t;

	logic clk;
	logic arst_n;

	r2a_in_if #(.VALUE_BITS(VALUE_W)) number_ch ();
	r2a_out_if                        digit_ch ();

	radix_to_ascii_digits_top #(
		.VALUE_BITS  (VALUE_W),
		.STACK_DEPTH (r2a_pkg::STACK_DEPTH_DEF)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.number_ch (number_ch),
		.digit_ch  (digit_ch)
	);

	// Digits still owed by the block, oldest first.
	digit_t pending_digits[$];

	int error_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_off_left  = 0;
	int quiet_cycles   = 0;

	// 10 ns clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Print one line per mismatch (capped so a dead block cannot flood the log) and count it.
	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Convert the magnitude of value into digits, most significant first, and
	// queue one expected digit transaction per digit.
	function automatic void predict_digits(input logic signed [VALUE_W-1:0] value,
			input logic [RW-1:0] radix);
		logic [VALUE_W-1:0] raw;
		logic [VALUE_W-1:0] negated;
		longint unsigned    magnitude;
		longint unsigned    base;
		logic [RW-1:0]      digit_vals[$];
		logic [RW-1:0]      d;
		digit_t             item;
		raw       = value;
		negated   = ~raw + 1'b1;
		magnitude = raw[VALUE_W-1] ? 64'(negated) : 64'(raw);
		// The most negative value has no positive twin: saturate it.
		if (magnitude > ((64'd1 << (VALUE_W - 1)) - 1))
			magnitude = (64'd1 << (VALUE_W - 1)) - 1;
		base = 64'(radix);
		if (base < r2a_pkg::RADIX_MIN)
			base = 64'(r2a_pkg::RADIX_MIN);
		if (base > r2a_pkg::RADIX_MAX)
			base = 64'(r2a_pkg::RADIX_MAX);
		// Least significant digit first; the final quotient is the leading digit.
		while (magnitude >= base) begin
			digit_vals.push_back(RW'(magnitude % base));
			magnitude = magnitude / base;
		end
		digit_vals.push_back(RW'(magnitude));
		for (int k = digit_vals.size() - 1; k >= 0; k--) begin
			d = digit_vals[k];
			if (d < r2a_pkg::DECIMAL_DIGITS)
				item.digit_char = r2a_pkg::CHAR_ZERO + CW'(d);
			else
				item.digit_char = r2a_pkg::CHAR_UPPER_A + CW'(d)
					- CW'(r2a_pkg::DECIMAL_DIGITS);
			item.last_digit = (k == 0);
			pending_digits.push_back(item);
		end
	endfunction

	// Offer one number transaction and hold it until the block takes it. Valid is
	// left high on return so a back-to-back call keeps streaming; any caller that
	// lets time pass afterwards must drop it first.
	task automatic send_number(input logic signed [VALUE_W-1:0] value,
			input logic [RW-1:0] radix);
		while ($urandom_range(99) < send_idle_pct) begin
			number_ch.valid <= 1'b0;
			@(posedge clk);
		end
		number_ch.valid        <= 1'b1;
		number_ch.number_value <= value;
		number_ch.target_radix <= radix;
		do
			@(posedge clk);
		while (!number_ch.ready);
		predict_digits(value, radix);
	endtask

	// Drop valid and wait until every owed digit has come back.
	task automatic wait_for_drain();
		number_ch.valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Zero, the extremes of both fields, every letter boundary, the saturated
	// most negative value and radixes outside 2..36 on either side.
	task automatic test_directed_cases();
		send_number(32'sd0, 6'd10);
		send_number(32'sd0, 6'd2);
		send_number(32'sd0, 6'd36);
		send_number(32'sd1, 6'd2);
		send_number(32'sd9, 6'd10);
		send_number(32'sd10, 6'd16);
		send_number(32'sd35, 6'd36);
		send_number(32'sd36, 6'd36);
		send_number(32'sh7FFF_FFFF, 6'd2);
		send_number(32'sh7FFF_FFFF, 6'd10);
		send_number(32'sh7FFF_FFFF, 6'd16);
		send_number(32'sh7FFF_FFFF, 6'd36);
		send_number(-32'sh7FFF_FFFF, 6'd10);
		send_number(-32'sd1, 6'd2);
		send_number(-32'sd12345, 6'd8);
		send_number(32'sh8000_0000, 6'd10);
		send_number(32'sh8000_0000, 6'd2);
		send_number(32'sd255, 6'd0);
		send_number(32'sd255, 6'd1);
		send_number(32'sd1295, 6'd37);
		send_number(32'sd1295, 6'd63);
		send_number(32'sd100, 6'd35);
		wait_for_drain();
	endtask

	// Random numbers, mostly short to mid-length strings, a few full-width ones,
	// and now and then a radix outside the nominal range.
	task automatic test_random_traffic(input int count);
		logic signed [VALUE_W-1:0] value;
		logic [RW-1:0]             radix;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0:       value = $urandom;
				1:       value = $urandom_range(1000);
				2:       value = $urandom >> $urandom_range(31);
				default: value = $urandom_range(40);
			endcase
			if ($urandom_range(1))
				value = -value;
			if ($urandom_range(9) == 0)
				radix = RW'($urandom_range(63));
			else
				radix = RW'($urandom_range(r2a_pkg::RADIX_MAX, r2a_pkg::RADIX_MIN));
			send_number(value, radix);
		end
	endtask

	// Hold the digit channel off for a long stretch while numbers keep arriving,
	// so the job queue fills and the block must stall its input.
	task automatic test_output_hold_off();
		set_idling(0, 0);
		hold_off_left = HOLD_OFF_LEN;
		for (int i = 0; i < 10; i++)
			send_number(VALUE_W'($urandom_range(99999)), RW'(10 + (i % 3) * 3));
		wait_for_drain();
	endtask

	// Pause the input until the block has emptied, then resume.
	task automatic test_drain_pause();
		set_idling(22, 22);
		test_random_traffic(6);
		wait_for_drain();
		test_random_traffic(6);
		wait_for_drain();
	endtask

	// Digit channel ready: a pending hold-off wins, else stall at the phase rate.
	initial begin
		digit_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				digit_ch.ready <= 1'b0;
				hold_off_left--;
			end else begin
				digit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compare each digit transaction with the oldest owed digit.
	always @(posedge clk) begin
		digit_t want;
		if (arst_n && digit_ch.valid && digit_ch.ready) begin
			if (pending_digits.size() == 0) begin
				report_mismatch($sformatf("unexpected digit 0x%02h last=%0b",
					digit_ch.digit_char, digit_ch.last_digit));
			end else begin
				want = pending_digits.pop_front();
				if (digit_ch.digit_char !== want.digit_char)
					report_mismatch($sformatf("digit_char 0x%02h, want 0x%02h",
						digit_ch.digit_char, want.digit_char));
				if (digit_ch.last_digit !== want.last_digit)
					report_mismatch($sformatf("last_digit %0b, want %0b",
						digit_ch.last_digit, want.last_digit));
			end
		end
	end

	// Watchdog: end the run if no transaction moves on either channel for too long.
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((number_ch.valid && number_ch.ready) || (digit_ch.valid && digit_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		// Drive every block input to a known value before the first edge.
		arst_n                 <= 1'b0;
		number_ch.valid        <= 1'b0;
		number_ch.number_value <= '0;
		number_ch.target_radix <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();

		// Idling phases: none, input gaps, output stalls, both.
		set_idling(0, 0);
		test_random_traffic(50);
		set_idling(55, 0);
		test_random_traffic(50);
		set_idling(0, 55);
		test_random_traffic(50);
		set_idling(22, 22);
		test_random_traffic(40);

		test_output_hold_off();
		test_drain_pause();

		// Let any stray output show up before the verdict.
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_digits.size() != 0)
			report_mismatch($sformatf("%0d digits never arrived", pending_digits.size()));

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
